[src/tbrl_pkg.sv]
// ----------------------------------------------------------------------------
// tbrl_pkg - token bucket rate limiter shared definitions
// Field widths, register index codes and the structs passed between modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tbrl_pkg;

    // field widths
    localparam int TOK_W  = 32;                 // token counts and tick period
    localparam int TIME_W = 63;                 // millisecond timestamps
    localparam int PROD_W = TOK_W + 2;          // serial product, sticky past 2^(TOK_W+1)
    localparam int CNT_W  = $clog2(TIME_W);     // divider step counter
    localparam int IDX_W  = 2;                  // config register index

    // config register indexes
    typedef enum logic [IDX_W-1:0] {
        CFG_BUCKET_LIMIT    = 2'd0,
        CFG_TOKENS_PER_TICK = 2'd1,
        CFG_TICK_PERIOD     = 2'd2,
        CFG_START_TIME      = 2'd3
    } t_cfg_idx;

    // live configuration values
    typedef struct packed {
        logic [TOK_W-1:0] bucket_limit;
        logic [TOK_W-1:0] tokens_per_tick;
        logic [TOK_W-1:0] tick_period;
    } t_cfg;

    // state loads caused by a config write
    typedef struct packed {
        logic              level_ld;
        logic              last_ld;
        logic [TIME_W-1:0] value;
    } t_cfg_load;

    // divider request
    typedef struct packed {
        logic              start;
        logic [TIME_W-1:0] dividend;
        logic [TOK_W-1:0]  divisor;
        logic [TOK_W-1:0]  mult;
    } t_div_req;

    // divider result: remainder and quotient * mult (saturating)
    typedef struct packed {
        logic [TOK_W-1:0]  rem;
        logic              sat;
        logic [PROD_W-1:0] prod;
    } t_div_res;

endpackage

`default_nettype wire

[src/token_bucket_rate_limiter_top.sv]
// ----------------------------------------------------------------------------
// token_bucket_rate_limiter_top - token bucket admission control
// Refills a token bucket by whole elapsed tick periods and grants requests.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (i_in_valid / o_in_ready) carries take_tokens and now_ms.
//   Result channel (o_out_valid / i_out_ready) returns one granted bit per
//   request, in order. Config channel (i_cfg_valid / o_cfg_ready) is always
//   ready; write it only while no request is in flight. Writing bucket_limit
//   also fills the bucket; writing start_time_ms seeds the last tick time.
// Sequence:
//   A request that needs no refill goes from the check step straight to the
//   grant step. A refill adds a divide step and a refill step before grant;
//   the divide step runs the serial divider over all 63 bits of elapsed time,
//   one bit per cycle; that divider sets the throughput. One request at a time.
// Reset:
//   Synchronous, active low; clears the bucket, tick time and registers
//   (tick period resets to 1) and empties the result register.
// Stall:
//   A new request is taken while a result waits; a finished request holds
//   in its last step until the result register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module token_bucket_rate_limiter_top import tbrl_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // request channel
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [TOK_W-1:0]  i_take_tokens,
    input  wire logic [TIME_W-1:0] i_now_ms,
    // result channel
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic                   o_granted,
    // config channel
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [IDX_W-1:0]  i_cfg_index,
    input  wire logic [TIME_W-1:0] i_cfg_data
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_CHECK  = 5'b00010,
        S_DIV    = 5'b00100,
        S_REFILL = 5'b01000,
        S_GRANT  = 5'b10000
    } t_state;

    t_cfg      w_cfg;
    t_cfg_load w_load;
    t_div_req  w_div_req;
    t_div_res  w_div_res;
    logic      w_div_done;

    t_state            r_state, n_state;
    logic [TOK_W-1:0]  r_level, n_level;
    logic [TIME_W-1:0] r_last, n_last;
    logic              r_out_valid, n_out_valid;
    logic              r_granted, n_granted;
    logic [TOK_W-1:0]  r_take;
    logic [TIME_W-1:0] r_now;
    logic [TIME_W-1:0] r_elapsed;
    logic              r_back;

    logic              w_in_acc;
    logic              w_out_free;
    logic [TIME_W:0]   w_diff;
    logic              w_need_refill;
    logic [TIME_W-1:0] w_last_new;
    logic [TOK_W+2:0]  w_sum;
    logic              w_cap;
    logic              w_grant;

    // config registers
    tbrl_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg),
        .o_load      (w_load)
    );

    // serial divider: remainder and saturating ticks * tokens_per_tick
    assign w_div_req.start    = (r_state == S_CHECK) && w_need_refill;
    assign w_div_req.dividend = r_elapsed;
    assign w_div_req.divisor  = w_cfg.tick_period;
    assign w_div_req.mult     = w_cfg.tokens_per_tick;

    tbrl_serdiv u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_done  (w_div_done),
        .o_res   (w_div_res)
    );

    // handshakes
    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_granted   = r_granted;

    // elapsed time; borrow flags time running backwards
    assign w_diff = {1'b0, i_now_ms} - {1'b0, r_last};

    // refill only when strictly more than one period has passed
    assign w_need_refill = !r_back && (w_cfg.tick_period != '0)
                           && (r_elapsed > {{(TIME_W-TOK_W){1'b0}}, w_cfg.tick_period});

    // advance tick time by whole periods, add tokens and cap
    assign w_last_new = r_now - {{(TIME_W-TOK_W){1'b0}}, w_div_res.rem};
    assign w_sum      = {3'b000, r_level} + {1'b0, w_div_res.prod};
    assign w_cap      = w_div_res.sat || (w_sum > {3'b000, w_cfg.bucket_limit});

    assign w_grant = (r_level > r_take);

    // next state
    always_comb begin
        n_state     = r_state;
        n_level     = r_level;
        n_last      = r_last;
        n_out_valid = r_out_valid;
        n_granted   = r_granted;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = w_need_refill ? S_DIV : S_GRANT;
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_state = S_REFILL;
                end
            end
            S_REFILL: begin
                n_last  = w_last_new;
                n_level = w_cap ? w_cfg.bucket_limit : w_sum[TOK_W-1:0];
                n_state = S_GRANT;
            end
            S_GRANT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_granted   = w_grant;
                    if (w_grant) begin
                        n_level = r_level - r_take;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        // config loads
        if (w_load.level_ld) begin
            n_level = w_load.value[TOK_W-1:0];
        end
        if (w_load.last_ld) begin
            n_last = w_load.value;
        end
    end

    // control and bucket state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_level     <= '0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_level     <= n_level;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
        end
    end

    // request word and result payload
    always_ff @(posedge i_clk) begin
        r_granted <= n_granted;
        if (w_in_acc) begin
            r_take    <= i_take_tokens;
            r_now     <= i_now_ms;
            r_elapsed <= w_diff[TIME_W-1:0];
            r_back    <= w_diff[TIME_W];
        end
    end

`ifndef SYNTHESIS
    // divider finishes only while the sequencer waits on it
    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV))
        else $error("divider done outside divide step");

    // a refill never leaves the bucket above its limit
    a_refill_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REFILL) |=> (r_level <= w_cfg.bucket_limit))
        else $error("bucket above limit after refill");

    // tick time never advances past the request time
    a_tick_not_ahead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_REFILL) && !w_load.last_ld) |=> (r_last <= r_now))
        else $error("tick time passed request time");

    // a bucket above the take yields a grant
    a_grant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_GRANT) && w_out_free && w_grant) |=> (r_out_valid && r_granted))
        else $error("grant not reported");
`endif

endmodule

`default_nettype wire

[src/tbrl_cfg.sv]
// ----------------------------------------------------------------------------
// tbrl_cfg - configuration register file
// Holds limit, refill rate and tick period; flags loads of bucket and tick time.
// ----------------------------------------------------------------------------
`default_nettype none

module tbrl_cfg import tbrl_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [IDX_W-1:0]  i_cfg_index,
    input  wire logic [TIME_W-1:0] i_cfg_data,
    output t_cfg                   o_cfg,
    output t_cfg_load              o_load
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // write decode
    always_comb begin
        n_cfg           = r_cfg;
        o_load.level_ld = 1'b0;
        o_load.last_ld  = 1'b0;
        o_load.value    = i_cfg_data;
        if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_BUCKET_LIMIT: begin
                    n_cfg.bucket_limit = i_cfg_data[TOK_W-1:0];
                    o_load.level_ld    = 1'b1;
                end
                CFG_TOKENS_PER_TICK: begin
                    n_cfg.tokens_per_tick = i_cfg_data[TOK_W-1:0];
                end
                CFG_TICK_PERIOD: begin
                    n_cfg.tick_period = i_cfg_data[TOK_W-1:0];
                end
                CFG_START_TIME: begin
                    o_load.last_ld = 1'b1;
                end
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bucket_limit    <= '0;
            r_cfg.tokens_per_tick <= '0;
            r_cfg.tick_period     <= TOK_W'(1);
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

`default_nettype wire

[src/tbrl_serdiv.sv]
// ----------------------------------------------------------------------------
// tbrl_serdiv - bit-serial divider with running product
// Restoring division, one quotient bit per cycle, MSB first. Each quotient bit
// is folded into quotient * mult by Horner's rule, saturating (sticky).
// ----------------------------------------------------------------------------
`default_nettype none

module tbrl_serdiv import tbrl_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output logic          o_done,
    output t_div_res      o_res
);

    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(TIME_W - 1);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [TIME_W-1:0] r_dvd;
    logic [TOK_W-1:0]  r_dvs;
    logic [TOK_W-1:0]  r_mul;
    logic [TOK_W-1:0]  r_rem;
    logic [PROD_W-1:0] r_prod;
    logic              r_sat;

    logic [TOK_W:0]    w_trial;
    logic [TOK_W+1:0]  w_diff;
    logic              w_qbit;
    logic [TOK_W-1:0]  n_rem;
    logic [PROD_W:0]   w_mac;
    logic              n_sat;

    // one compare-subtract step on the partial remainder
    assign w_trial = {r_rem, r_dvd[TIME_W-1]};
    assign w_diff  = {1'b0, w_trial} - {2'b00, r_dvs};
    assign w_qbit  = !w_diff[TOK_W+1];
    assign n_rem   = w_qbit ? w_diff[TOK_W-1:0] : w_trial[TOK_W-1:0];

    // product = 2 * product + qbit * mult; sticky once it passes 2^(TOK_W+1)
    assign w_mac = {r_prod, 1'b0} + (w_qbit ? {3'b000, r_mul} : '0);
    assign n_sat = r_sat | w_mac[PROD_W] | w_mac[PROD_W-1];

    assign o_done     = r_done;
    assign o_res.rem  = r_rem;
    assign o_res.sat  = r_sat;
    assign o_res.prod = r_prod;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvd  <= i_req.dividend;
            r_dvs  <= i_req.divisor;
            r_mul  <= i_req.mult;
            r_rem  <= '0;
            r_prod <= '0;
            r_sat  <= 1'b0;
        end else if (r_busy) begin
            r_dvd  <= {r_dvd[TIME_W-2:0], 1'b0};
            r_rem  <= n_rem;
            r_prod <= w_mac[PROD_W-1:0];
            r_sat  <= n_sat;
        end
    end

endmodule

`default_nettype wire
